>>> rtl/bf3_pkg.sv
// bf3_pkg: shared constants and types for the three-hash bloom filter
// operation codes, hash multipliers, store geometry and the sequencer state type
// no dependencies
package bf3_pkg;

    // default filter size in bits
    localparam int unsigned FILTER_BITS_DEF = 8192;

    // operation codes carried by the kind field
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // multiplicative hash constants
    localparam logic [31:0] HASH_MUL_A = 32'd2654435761;
    localparam logic [31:0] HASH_MUL_B = 32'h85ebca6b;
    localparam logic [31:0] HASH_MUL_C = 32'hcc9e2d51;
    localparam int unsigned MIX_SHIFT  = 16;
    localparam int unsigned KEY_BITS   = 32;

    // three positions per key, probe index runs 0..2
    localparam logic [1:0] PROBE_LAST = 2'd2;

    // store rows are up to 2**STORE_WORD_SHIFT bits wide
    localparam int unsigned STORE_WORD_SHIFT = 5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK
    } t_bf3_state;

endpackage

>>> rtl/bf3_store.sv
// bf3_store: single-port synchronous bit store, one row read or written per cycle
// read data is registered
// no package dependencies
module bf3_store #(
    parameter int unsigned ROWS   = 256,
    parameter int unsigned ROW_W  = 8,
    parameter int unsigned WORD_W = 32
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ROW_W-1:0]  i_addr,
    input  logic [WORD_W-1:0] i_wdata,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [ROWS];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && !i_we) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bf3_hash.sv
// bf3_hash: computes the three bit positions of a key modulo the filter size
// power-of-two sizes use a registered truncated multiply, other sizes a 32-step
// serial modular multiply; depends on bf3_pkg
module bf3_hash #(
    parameter int unsigned FILTER_BITS = bf3_pkg::FILTER_BITS_DEF,
    parameter int unsigned POS_W       = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_key,
    output logic                  o_done,
    output logic [2:0][POS_W-1:0] o_pos
);

    import bf3_pkg::*;

    localparam bit IS_POW2 = (FILTER_BITS & (FILTER_BITS - 1)) == 0;

    logic [31:0] mixed;
    assign mixed = i_key ^ (i_key >> MIX_SHIFT);

    generate
        if (IS_POW2) begin : g_pow2
            // modulo a power of two keeps only the low bits of the product
            localparam logic [POS_W-1:0] CA = HASH_MUL_A[POS_W-1:0];
            localparam logic [POS_W-1:0] CB = HASH_MUL_B[POS_W-1:0];
            localparam logic [POS_W-1:0] CC = HASH_MUL_C[POS_W-1:0];

            logic [2*POS_W-1:0]    prod_a, prod_b, prod_c;
            logic [2:0][POS_W-1:0] r_pos;
            logic                  r_done;

            assign prod_a = i_key[POS_W-1:0] * CA;
            assign prod_b = i_key[POS_W-1:0] * CB;
            assign prod_c = mixed[POS_W-1:0] * CC;

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_pos[0] <= prod_a[POS_W-1:0];
                    r_pos[1] <= prod_b[POS_W-1:0];
                    r_pos[2] <= prod_c[POS_W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            assign o_done = r_done;
            assign o_pos  = r_pos;
        end else begin : g_serial
            // horner over key bits, msb first: acc = (2*acc + bit*(C mod N)) mod N
            localparam int unsigned ACC_W = POS_W + 2;
            localparam int unsigned CNT_W = $clog2(KEY_BITS);
            localparam logic [63:0] CM_A = 64'(HASH_MUL_A) % 64'(FILTER_BITS);
            localparam logic [63:0] CM_B = 64'(HASH_MUL_B) % 64'(FILTER_BITS);
            localparam logic [63:0] CM_C = 64'(HASH_MUL_C) % 64'(FILTER_BITS);
            localparam logic [2:0][POS_W-1:0] CMS =
                {POS_W'(CM_C), POS_W'(CM_B), POS_W'(CM_A)};
            localparam logic [ACC_W-1:0] N1 = ACC_W'(FILTER_BITS);
            localparam logic [ACC_W-1:0] N2 = ACC_W'(2 * FILTER_BITS);
            localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_BITS - 1);

            logic [31:0]           r_key, r_mix;
            logic [2:0][POS_W-1:0] r_acc;
            logic [2:0][POS_W-1:0] n_acc;
            logic [CNT_W-1:0]      r_cnt;
            logic                  r_run;
            logic                  r_done;
            logic [2:0]            step_bit;
            logic [ACC_W-1:0]      sum [3];

            assign step_bit = {r_mix[31], r_key[31], r_key[31]};

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    sum[i] = {1'b0, r_acc[i], 1'b0}
                           + ACC_W'(step_bit[i] ? CMS[i] : '0);
                    if (sum[i] >= N2) begin
                        n_acc[i] = POS_W'(sum[i] - N2);
                    end else if (sum[i] >= N1) begin
                        n_acc[i] = POS_W'(sum[i] - N1);
                    end else begin
                        n_acc[i] = POS_W'(sum[i]);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                    r_mix <= mixed;
                    r_acc <= '0;
                end else if (r_run) begin
                    r_key <= {r_key[30:0], 1'b0};
                    r_mix <= {r_mix[30:0], 1'b0};
                    r_acc <= n_acc;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_run <= 1'b1;
                        r_cnt <= '0;
                    end else if (r_run) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_LAST) begin
                            r_run  <= 1'b0;
                            r_done <= 1'b1;
                        end
                    end
                end
            end

            assign o_done = r_done;
            assign o_pos  = r_acc;
        end
    endgenerate

endmodule

>>> rtl/bloom_filter_three_hash.sv
// bloom_filter_three_hash: three-hash bloom filter over a word-organized bit store
// add/query: after accept, the hash (a registered multiply when FILTER_BITS is a power of two,
// else serial), then a read and a check state per probe on one store port; then idle again
// query result strobes on o_result_valid, registered from the last check state; receiver cannot stall
// clear: zeros every store row in turn; the same pass runs after reset, busy high
// depends on bf3_pkg, bf3_hash, bf3_store
module bloom_filter_three_hash #(
    parameter int unsigned FILTER_BITS = bf3_pkg::FILTER_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_key_value,
    output logic        o_result_valid,
    output logic        o_maybe_present
);

    import bf3_pkg::*;

    // position width, and how a position splits into row and bit-in-row
    localparam int unsigned POS_W  = $clog2(FILTER_BITS);
    localparam int unsigned BIT_W  = (POS_W < STORE_WORD_SHIFT) ? POS_W : STORE_WORD_SHIFT;
    localparam int unsigned WORD_W = 2 ** BIT_W;
    localparam int unsigned ROWS   = (FILTER_BITS + WORD_W - 1) / WORD_W;
    localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

    t_bf3_state r_state, n_state;
    logic [1:0]       r_idx, n_idx;
    logic             r_is_query, n_is_query;
    logic             r_hit, n_hit;
    logic [ROW_W-1:0] r_clr_row, n_clr_row;
    logic             r_valid, n_valid;
    logic             r_result, n_result;

    // hash unit
    logic                  hash_start;
    logic                  hash_done;
    logic [2:0][POS_W-1:0] hash_pos;

    // store port
    logic              mem_en, mem_we;
    logic [ROW_W-1:0]  mem_addr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;

    // current probe position split into row and bit
    logic [POS_W-1:0]  probe_pos;
    logic [POS_W-1:0]  probe_shift;
    logic [ROW_W-1:0]  probe_row;
    logic [BIT_W-1:0]  probe_bit;
    logic              probe_set;

    logic accept;

    assign accept      = start && !busy;
    assign probe_pos   = hash_pos[r_idx];
    assign probe_shift = probe_pos >> BIT_W;
    assign probe_row   = ROW_W'(probe_shift);
    assign probe_bit   = probe_pos[BIT_W-1:0];
    assign probe_set   = mem_rdata[probe_bit];

    bf3_hash #(
        .FILTER_BITS (FILTER_BITS),
        .POS_W       (POS_W)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (i_key_value),
        .o_done  (hash_done),
        .o_pos   (hash_pos)
    );

    bf3_store #(
        .ROWS   (ROWS),
        .ROW_W  (ROW_W),
        .WORD_W (WORD_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == ROW_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        OP_ADD:   n_state = ST_HASH;
                        OP_QUERY: n_state = ST_HASH;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_IDLE;  // unused kind is a no-op
                    endcase
                end
            end
            ST_HASH: begin
                if (hash_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // each probe writes back before the next read, so no forwarding needed
                n_state = (r_idx == PROBE_LAST) ? ST_IDLE : ST_READ;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath next values
    always_comb begin
        busy       = (r_state != ST_IDLE);
        hash_start = 1'b0;
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = probe_row;
        mem_wdata  = mem_rdata;
        n_idx      = r_idx;
        n_is_query = r_is_query;
        n_hit      = r_hit;
        n_clr_row  = '0;
        n_valid    = 1'b0;
        n_result   = r_result;
        case (r_state)
            ST_CLEAR: begin
                // zero one row per cycle
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = r_clr_row;
                mem_wdata = '0;
                n_clr_row = r_clr_row + 1'b1;
            end
            ST_IDLE: begin
                if (accept && (i_kind == OP_ADD || i_kind == OP_QUERY)) begin
                    hash_start = 1'b1;
                end
                n_is_query = (i_kind == OP_QUERY);
                n_idx      = '0;
                n_hit      = 1'b1;
            end
            ST_HASH: begin
                n_idx = '0;
            end
            ST_READ: begin
                mem_en = 1'b1;
            end
            ST_CHECK: begin
                if (r_is_query) begin
                    n_hit = r_hit & probe_set;
                    if (r_idx == PROBE_LAST) begin
                        n_valid  = 1'b1;
                        n_result = r_hit & probe_set;
                    end
                end else begin
                    // read-modify-write of the probed row
                    mem_en              = 1'b1;
                    mem_we              = 1'b1;
                    mem_wdata[probe_bit] = 1'b1;
                end
                n_idx = (r_idx == PROBE_LAST) ? '0 : r_idx + 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;  // clearing pass after reset
            r_clr_row <= '0;
            r_valid   <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_row <= n_clr_row;
            r_valid   <= n_valid;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_query <= n_is_query;
        r_hit      <= n_hit;
        r_result   <= n_result;
    end

    assign o_result_valid  = r_valid;
    assign o_maybe_present = r_result;

endmodule

>>> sim/tb_top.sv
// tb_top: self-checking testbench for bloom_filter_three_hash (start/busy command port)
// a directed table and three random phases of words, checked against an in-bench bit store
// depends on bf3_pkg and the bloom_filter_three_hash rtl
module tb_top;

    import bf3_pkg::*;

    localparam int unsigned N_BITS     = FILTER_BITS_DEF;
    // unused encoding of the kind field: no effect, no result
    localparam logic [1:0]  OP_SPARE   = 2'd3;
    // longest quiet stretch: reset clear pass plus a clear plus a long sender gap
    localparam int unsigned WDOG_LIMIT = 4000;
    // drain time after the last query: covers a trailing clear of N_BITS/32 rows
    localparam int unsigned DRAIN_CYC  = 400;
    localparam int unsigned DIR_ROWS   = 25;
    localparam int unsigned PHASE_LEN  = 400;

    // one row of the directed table; typed rows carry a hand-written answer
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] key;
        logic        typed;
        logic        typed_hit;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic [1:0]  i_kind      = OP_ADD;
    logic [31:0] i_key_value = '0;
    logic        busy;
    logic        o_result_valid;
    logic        o_maybe_present;

    // mirror of the filter store and the answers still owed by the block
    bit          mirror_bits [N_BITS];
    logic        hit_queue [$];
    logic [31:0] added_keys [$];
    int unsigned fail_cnt  = 0;
    int unsigned quiet_cyc = 0;

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{OP_QUERY, 32'h0000_0000, 1'b1, 1'b0},  // empty store after reset
        '{OP_QUERY, 32'hffff_ffff, 1'b1, 1'b0},
        '{OP_ADD,   32'h0000_0000, 1'b0, 1'b0},  // key zero: all three positions coincide
        '{OP_QUERY, 32'h0000_0000, 1'b1, 1'b1},
        '{OP_ADD,   32'hffff_ffff, 1'b0, 1'b0},
        '{OP_QUERY, 32'hffff_ffff, 1'b1, 1'b1},
        '{OP_QUERY, 32'h0000_0001, 1'b0, 1'b0},
        '{OP_SPARE, 32'h1234_5678, 1'b0, 1'b0},  // unused kind must not touch the store
        '{OP_QUERY, 32'h1234_5678, 1'b0, 1'b0},
        '{OP_ADD,   32'h0001_0001, 1'b0, 1'b0},  // mixing step cancels the low half
        '{OP_QUERY, 32'h0001_0001, 1'b1, 1'b1},
        '{OP_CLEAR, 32'hdead_beef, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0000, 1'b1, 1'b0},
        '{OP_QUERY, 32'hffff_ffff, 1'b1, 1'b0},
        '{OP_SPARE, 32'hffff_ffff, 1'b0, 1'b0},
        '{OP_ADD,   32'haaaa_aaaa, 1'b0, 1'b0},
        '{OP_ADD,   32'h5555_5555, 1'b0, 1'b0},
        '{OP_QUERY, 32'haaaa_aaaa, 1'b1, 1'b1},
        '{OP_QUERY, 32'h5555_5555, 1'b1, 1'b1},
        '{OP_QUERY, 32'h8000_0000, 1'b0, 1'b0},
        '{OP_CLEAR, 32'h0000_0000, 1'b0, 1'b0},
        '{OP_CLEAR, 32'hffff_ffff, 1'b0, 1'b0},  // back-to-back clears
        '{OP_QUERY, 32'haaaa_aaaa, 1'b1, 1'b0},
        '{OP_ADD,   32'h0000_0001, 1'b0, 1'b0},
        '{OP_QUERY, 32'h0000_0002, 1'b0, 1'b0}
    };

    bloom_filter_three_hash u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_key_value     (i_key_value),
        .o_result_valid  (o_result_valid),
        .o_maybe_present (o_maybe_present)
    );

    // 4-unit clock, first rising edge at 2
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // the three bit positions of a key, products kept in 64 bits
    function automatic int unsigned probe_pos(input logic [31:0] key, input int unsigned which);
        logic [63:0] mixed;
        logic [63:0] prod;
        mixed = {32'd0, key};
        case (which)
            0: prod = mixed * 64'd2654435761;
            1: prod = mixed * 64'h85eb_ca6b;
            default: begin
                mixed = {32'd0, key ^ (key >> 16)};
                prod  = mixed * 64'hcc9e_2d51;
            end
        endcase
        return int'(prod % 64'(N_BITS));
    endfunction

    // apply one accepted word to the mirror; returns 1 when a query answer is owed
    function automatic bit bloom_predict(input logic [1:0] kind, input logic [31:0] key,
                                         output logic hit);
        hit = 1'b1;
        case (kind)
            OP_ADD: begin
                for (int p = 0; p < 3; p++) mirror_bits[probe_pos(key, p)] = 1'b1;
                return 1'b0;
            end
            OP_QUERY: begin
                for (int p = 0; p < 3; p++) begin
                    if (!mirror_bits[probe_pos(key, p)]) hit = 1'b0;
                end
                return 1'b1;
            end
            OP_CLEAR: begin
                foreach (mirror_bits[i]) mirror_bits[i] = 1'b0;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    // present one word, hold it until the block takes it, then log the owed answer
    task automatic issue_word(input logic [1:0] kind, input logic [31:0] key,
                              input logic typed, input logic typed_hit);
        logic hit;
        start       <= 1'b1;
        i_kind      <= kind;
        i_key_value <= key;
        do @(posedge i_clk); while (busy);
        if (bloom_predict(kind, key, hit)) hit_queue.push_back(typed ? typed_hit : hit);
        if (kind == OP_ADD) added_keys.push_front(key);
    endtask

    // sender gap: with chance pct percent, start is dropped with junk on the payload,
    // for a gap drawn long enough to end in any state of an add/query
    task automatic sender_gap(input int unsigned pct);
        if ($urandom_range(99) < pct) begin
            start       <= 1'b0;
            i_kind      <= 2'($urandom);
            i_key_value <= $urandom;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    // one random word: mostly adds and queries, queries often replay a recent key
    task automatic random_word();
        int unsigned roll;
        logic [1:0]  kind;
        logic [31:0] key;
        roll = $urandom_range(99);
        if (roll < 42) kind = OP_ADD;
        else if (roll < 94) kind = OP_QUERY;
        else if (roll < 97) kind = OP_SPARE;
        else kind = OP_CLEAR;
        key = $urandom;
        if (kind == OP_QUERY && added_keys.size() > 0 && $urandom_range(1) == 1) begin
            key = added_keys[$urandom_range((added_keys.size() > 32 ? 32 : added_keys.size()) - 1)];
        end
        if ($urandom_range(19) == 0) key = $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
        issue_word(kind, key, 1'b0, 1'b0);
    endtask

    // answer checker: every strobe must match the oldest owed answer
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (hit_queue.size() == 0) begin
                $error("maybe_present: expected none, actual %0b", o_maybe_present);
                fail_cnt++;
            end else begin
                logic owed;
                owed = hit_queue.pop_front();
                if (o_maybe_present !== owed) begin
                    $error("maybe_present: expected %0b, actual %0b", owed, o_maybe_present);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no word taken and no answer strobed
    always @(posedge i_clk) begin
        if ((start && !busy && i_rst_n) || o_result_valid) begin
            quiet_cyc <= 0;
        end else begin
            quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= WDOG_LIMIT) begin
                $display("FAIL bloom_filter_three_hash");
                $finish;
            end
        end
    end

    initial begin
        // reset held at the start; the block then runs its clearing pass with busy high
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            issue_word(dir_rows[r].kind, dir_rows[r].key, dir_rows[r].typed,
                       dir_rows[r].typed_hit);
            sender_gap(22);
        end

        // random phases: light sender idling, heavy idling, then back to back
        for (int n = 0; n < PHASE_LEN; n++) begin
            random_word();
            sender_gap(22);
        end
        for (int n = 0; n < PHASE_LEN; n++) begin
            random_word();
            sender_gap(58);
        end
        for (int n = 0; n < PHASE_LEN; n++) begin
            random_word();
        end

        start <= 1'b0;
        // drain owed answers, then let a trailing clear finish
        while (hit_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (hit_queue.size() != 0) begin
            $error("maybe_present: %0d answers never arrived", hit_queue.size());
            fail_cnt++;
        end
        if (fail_cnt == 0) begin
            $display("PASS bloom_filter_three_hash");
        end else begin
            $display("FAIL bloom_filter_three_hash");
        end
        $finish;
    end

endmodule
